// File: rtl/rcfa_pkg.sv
// ----------------------------------------------------------------------------
// rcfa_pkg
// Shared types and codes for the reference-counted frame allocator.
// ----------------------------------------------------------------------------
package rcfa_pkg;

	// Field widths fixed by the request and result formats
	localparam int IDX_W   = 6;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 8;

	// Defaults for the top-level parameters
	localparam int DEF_NUM_FRAMES = 32;
	localparam int DEF_COUNT_MAX  = 255;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Request command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SHARE   = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE  = 2'd2;
	localparam logic [STAT_W-1:0] ST_SAT    = 2'd3;

	// Classified operation handed from front to back
	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_RELEASE,
		OP_SHARE,
		OP_REJECT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] idx;
	} req_t;

	// One queue beat: valid plus classified request
	typedef struct packed {
		logic valid;
		req_t req;
	} req_beat_t;

endpackage

// File: rtl/rcfa_front.sv
// ----------------------------------------------------------------------------
// rcfa_front
// Accepts request beats, decodes the command and checks the frame index range.
// ----------------------------------------------------------------------------
module rcfa_front import rcfa_pkg::*; #(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES
) (
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CMD_W-1:0] command,
	input  logic [IDX_W-1:0] frame_index,
	input  logic             q_full,
	output req_beat_t        push
);

	localparam logic [IDX_W:0] NF = (IDX_W+1)'(NUM_FRAMES);

	logic in_range;
	op_t  op;

	// Hold the input while the queue has no room
	assign in_stall = q_full;

	assign in_range = {1'b0, frame_index} < NF;

	// Classify the beat; unknown commands and bad indexes on release or share are rejected
	always_comb begin
		unique case (command)
			CMD_ALLOC:   op = OP_ALLOC;
			CMD_RELEASE: op = in_range ? OP_RELEASE : OP_REJECT;
			CMD_SHARE:   op = in_range ? OP_SHARE : OP_REJECT;
			default:     op = OP_REJECT;
		endcase
	end

	assign push.valid   = in_valid && !q_full;
	assign push.req.op  = op;
	assign push.req.idx = frame_index;

endmodule

// File: rtl/rcfa_queue.sv
// ----------------------------------------------------------------------------
// rcfa_queue
// Small FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module rcfa_queue import rcfa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  req_beat_t push,
	output logic      full,
	input  logic      pop,
	output req_beat_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	req_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == FULL_CNT);
	assign head.valid = (count_q != '0);
	assign head.req   = entry_q[rd_ptr_q];

	assign do_push = push.valid && !full;
	assign do_pop  = pop && head.valid;

	// Store the pushed beat
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.req;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/rcfa_back.sv
// ----------------------------------------------------------------------------
// rcfa_back
// Executes requests: first-free search, count read-modify-write, result beat.
// ----------------------------------------------------------------------------
module rcfa_back import rcfa_pkg::*; #(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES,
	parameter int COUNT_MAX  = DEF_COUNT_MAX
) (
	input  logic               clk,
	input  logic               arst_n,
	input  req_beat_t          head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [IDX_W-1:0]   frame_out,
	output logic [COUNT_W-1:0] count_after
);

	localparam int AW = $clog2(NUM_FRAMES);
	localparam logic [COUNT_W-1:0] CMAX = COUNT_W'(COUNT_MAX);

	localparam logic ST_ISSUE = 1'b0;
	localparam logic ST_EXEC  = 1'b1;

	logic                  state_q;
	logic [NUM_FRAMES-1:0] used_q;
	logic [NUM_FRAMES-1:0] written_q;
	logic [COUNT_W-1:0]    refs_mem [NUM_FRAMES];
	logic [COUNT_W-1:0]    rd_q;
	logic                  rd_written_q;
	op_t                   op_q;
	logic [IDX_W-1:0]      idx_q;
	logic [AW-1:0]         addr_q;
	logic                  found_q;

	logic                  free_found;
	logic [AW-1:0]         free_idx;
	logic [AW-1:0]         issue_addr;
	logic                  fire;
	logic [COUNT_W-1:0]    cur;
	logic [COUNT_W-1:0]    new_count;
	logic                  sat;
	logic                  wr_en;
	logic [STAT_W-1:0]     res_status;
	logic [IDX_W-1:0]      res_frame;
	logic [COUNT_W-1:0]    res_count;

	// Find the lowest free frame
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	assign pop        = (state_q == ST_ISSUE) && head.valid;
	assign issue_addr = (head.req.op == OP_ALLOC) ? free_idx : head.req.idx[AW-1:0];
	assign fire       = (state_q == ST_EXEC) && (!out_valid || !out_stall);

	// Count memory: registered read at issue, write at execute
	always_ff @(posedge clk) begin
		if (pop) begin
			rd_q <= refs_mem[issue_addr];
		end
		if (wr_en) begin
			refs_mem[addr_q] <= new_count;
		end
	end

	// Latch the request being worked on
	always_ff @(posedge clk) begin
		if (pop) begin
			op_q    <= head.req.op;
			idx_q   <= head.req.idx;
			addr_q  <= issue_addr;
			found_q <= free_found;
		end
	end

	// Compute the new count and the result beat
	always_comb begin
		cur        = rd_written_q ? rd_q : '0;
		sat        = (cur >= CMAX);
		new_count  = cur;
		wr_en      = 1'b0;
		res_status = ST_OK;
		res_frame  = idx_q;
		res_count  = '0;
		unique case (op_q)
			OP_ALLOC: begin
				if (found_q) begin
					new_count  = sat ? CMAX : cur + 1'b1;
					wr_en      = fire;
					res_status = sat ? ST_SAT : ST_OK;
					res_frame  = IDX_W'(addr_q);
					res_count  = new_count;
				end else begin
					res_status = ST_NOFREE;
					res_frame  = '0;
				end
			end
			OP_RELEASE: begin
				new_count = (cur <= COUNT_W'(1)) ? '0 : cur - 1'b1;
				wr_en     = fire;
				res_count = new_count;
			end
			OP_SHARE: begin
				new_count  = sat ? CMAX : cur + 1'b1;
				wr_en      = fire;
				res_status = sat ? ST_SAT : ST_OK;
				res_count  = new_count;
			end
			OP_REJECT: begin
				res_status = ST_RANGE;
			end
			default: begin
				res_status = ST_RANGE;
			end
		endcase
	end

	// Sequencer, bitmap, written bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_ISSUE;
			used_q       <= '0;
			written_q    <= '0;
			rd_written_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (pop) begin
				rd_written_q <= written_q[issue_addr];
				state_q      <= ST_EXEC;
			end
			if (fire) begin
				state_q <= ST_ISSUE;
				if (wr_en) begin
					written_q[addr_q] <= 1'b1;
				end
				if (op_q == OP_ALLOC && found_q) begin
					used_q[addr_q] <= 1'b1;
				end else if (op_q == OP_RELEASE && new_count == '0) begin
					used_q[addr_q] <= 1'b0;
				end
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result payload; held while stalled
	always_ff @(posedge clk) begin
		if (fire) begin
			status      <= res_status;
			frame_out   <= res_frame;
			count_after <= res_count;
		end
	end

`ifndef ASSERT_OFF
	a_alloc_picks_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.req.op == OP_ALLOC && free_found |-> !used_q[issue_addr])
		else $error("allocate picked a used frame");

	a_alloc_marks_used: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_q == OP_ALLOC && found_q |=> used_q[$past(addr_q)])
		else $error("granted frame not marked used");

	a_nofree_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op_q == OP_ALLOC && !found_q |-> &used_q)
		else $error("no-free reported with a free frame");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_after <= CMAX)
		else $error("count above maximum");
`endif

endmodule

// File: rtl/refcounted_frame_allocator.sv
// Reference-counted frame allocator. Each request beat (allocate, release or
// share) yields exactly one result beat, in order. In the execute unit the
// issue step searches the used bitmap and registers the frame's count read
// from the count memory; the execute step then updates the count and bitmap
// and registers the result, waiting while a result is held by out_stall. No
// new request is taken until the current result is registered. A two-entry
// queue between the decoder and the execute unit lets input keep arriving
// while a result waits on out_stall. Reset frees every frame and clears the
// written bits so that all counts read as zero; there is no clearing pass.
// ----------------------------------------------------------------------------
// refcounted_frame_allocator
// Top level: request decoder, request queue and execute unit.
// ----------------------------------------------------------------------------
module refcounted_frame_allocator import rcfa_pkg::*; #(
	parameter int NUM_FRAMES = DEF_NUM_FRAMES,
	parameter int COUNT_MAX  = DEF_COUNT_MAX
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CMD_W-1:0]   command,
	input  logic [IDX_W-1:0]   frame_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [IDX_W-1:0]   frame_out,
	output logic [COUNT_W-1:0] count_after
);

	req_beat_t push;
	req_beat_t head;
	logic      q_full;
	logic      pop;

	rcfa_front #(
		.NUM_FRAMES (NUM_FRAMES)
	) u_front (
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.frame_index (frame_index),
		.q_full      (q_full),
		.push        (push)
	);

	rcfa_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	rcfa_back #(
		.NUM_FRAMES (NUM_FRAMES),
		.COUNT_MAX  (COUNT_MAX)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.frame_out   (frame_out),
		.count_after (count_after)
	);

endmodule
